// ----- hw/rtl/ssi_pkg.sv -----
package ssi_pkg;

   // Number of entries the store can hold (2 to 31; the response count is 5 bits).
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int KEY_W    = 32;
   localparam int FUNC_W   = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SEARCH = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_DUMP   = 2'd3
   } func_type;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic                    load_flags;
      logic                    do_insert;
      logic                    do_rotate;
      logic signed [KEY_W-1:0] key;
   } cell_ctrl_type;

endpackage

// ----- hw/rtl/ssi_req_if.sv -----
interface ssi_req_if;
   logic                             valid;
   logic                             ready;
   logic [ssi_pkg::FUNC_W-1:0]       func;
   logic signed [ssi_pkg::KEY_W-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

// ----- hw/rtl/ssi_rsp_if.sv -----
interface ssi_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              hit;
   logic                              inserted;
   logic                              full_res;
   logic [ssi_pkg::COUNT_W-1:0]       count;
   logic signed [ssi_pkg::KEY_W-1:0]  element;
   logic                              last;

   modport source (output valid, output hit, output inserted, output full_res,
                   output count, output element, output last, input ready);
   modport sink   (input valid, input hit, input inserted, input full_res,
                   input count, input element, input last, output ready);
endinterface

// ----- hw/rtl/sorted_set_insert_search.sv -----
// Sorted set of signed 32-bit keys, held in ascending order without
// duplicates in a chain of CAPACITY cells. Each request carries search,
// insert, clear or dump. For search, insert and clear, every cell compares
// its key with the request key in parallel when the request is accepted and
// registers the result; then, once the response register is free, the
// controller combines those flags, shifts the chain for an insert and loads
// the response register. A new request is accepted as soon as the controller
// is idle again, even while the previous response still waits to be taken. A
// dump of N entries takes those same steps and then sends N responses,
// rotating the chain one place per response so that the next key in order is
// always at the head; after N rotations the chain is back in order. The store
// needs no clearing after reset: only slots below the count are read.
module sorted_set_insert_search (
   input logic       clock,
   input logic       reset,
   ssi_req_if.sink   req_chan,
   ssi_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EVAL = 3'b010,
      ST_DUMP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [ssi_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [ssi_pkg::CNT_W-1:0]        dump_idx_ff, dump_idx_in;
   logic [ssi_pkg::FUNC_W-1:0]       func_ff, func_in;
   logic signed [ssi_pkg::KEY_W-1:0] key_ff, key_in;

   // Response register; it decouples the chain from the consumer.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_hit_ff, rsp_hit_in;
   logic                              rsp_inserted_ff, rsp_inserted_in;
   logic                              rsp_full_ff, rsp_full_in;
   logic [ssi_pkg::COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic signed [ssi_pkg::KEY_W-1:0]  rsp_element_ff, rsp_element_in;
   logic                              rsp_last_ff, rsp_last_in;

   ssi_pkg::cell_ctrl_type            ctrl;
   logic signed [ssi_pkg::KEY_W-1:0]  cell_data [ssi_pkg::CAPACITY];
   logic [ssi_pkg::CAPACITY-1:0]      cell_eq;
   logic [ssi_pkg::CAPACITY-1:0]      cell_gt;

   logic req_fire;
   logic out_free;
   logic any_hit;
   logic is_full;
   logic dump_last;
   logic do_insert;
   logic do_rotate;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign any_hit  = |cell_eq;
   assign is_full  = (cnt_ff == ssi_pkg::CNT_W'(ssi_pkg::CAPACITY));
   assign dump_last = ((dump_idx_ff + 1'b1) == cnt_ff);

   assign req_chan.ready = (state_ff == ST_IDLE);

   // Flags are loaded with the incoming key; the shift uses the held key.
   assign ctrl.load_flags = req_fire;
   assign ctrl.do_insert  = do_insert;
   assign ctrl.do_rotate  = do_rotate;
   assign ctrl.key        = req_fire ? req_chan.value : key_ff;

   // The cell chain. Each cell sees its neighbours and, for the rotation
   // during a dump, the head of the chain.
   for (genvar i = 0; i < ssi_pkg::CAPACITY; i++) begin : g_cell
      logic signed [ssi_pkg::KEY_W-1:0] left_data;
      logic                             left_gt;
      logic signed [ssi_pkg::KEY_W-1:0] right_data;

      if (i == 0) begin : g_head
         assign left_data = '0;
         assign left_gt   = 1'b0;
      end else begin : g_body
         assign left_data = cell_data[i-1];
         assign left_gt   = cell_gt[i-1];
      end

      if (i == ssi_pkg::CAPACITY - 1) begin : g_end
         assign right_data = cell_data[0];
      end else begin : g_mid
         assign right_data = cell_data[i+1];
      end

      ssi_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .slot_valid (ssi_pkg::CNT_W'(i) < cnt_ff),
         .slot_tail  (ssi_pkg::CNT_W'(i + 1) == cnt_ff),
         .left_data  (left_data),
         .left_gt    (left_gt),
         .right_data (right_data),
         .head_data  (cell_data[0]),
         .data       (cell_data[i]),
         .eq         (cell_eq[i]),
         .gt         (cell_gt[i])
      );
   end

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      dump_idx_in     = dump_idx_ff;
      func_in         = func_ff;
      key_in          = key_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_hit_in      = rsp_hit_ff;
      rsp_inserted_in = rsp_inserted_ff;
      rsp_full_in     = rsp_full_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_element_in  = rsp_element_ff;
      rsp_last_in     = rsp_last_ff;
      do_insert       = 1'b0;
      do_rotate       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in  = req_chan.func;
               key_in   = req_chan.value;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (out_free) begin
               rsp_hit_in      = 1'b0;
               rsp_inserted_in = 1'b0;
               rsp_full_in     = 1'b0;
               rsp_element_in  = '0;
               rsp_last_in     = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
               case (func_ff)
                  ssi_pkg::FUNC_SEARCH: begin
                     rsp_hit_in = any_hit;
                  end
                  ssi_pkg::FUNC_INSERT: begin
                     if (any_hit) begin
                        rsp_hit_in = 1'b1;
                     end else if (is_full) begin
                        rsp_full_in = 1'b1;
                     end else begin
                        do_insert       = 1'b1;
                        cnt_in          = cnt_ff + 1'b1;
                        rsp_inserted_in = 1'b1;
                     end
                  end
                  ssi_pkg::FUNC_CLEAR: begin
                     cnt_in = '0;
                  end
                  ssi_pkg::FUNC_DUMP: begin
                     if (cnt_ff != '0) begin
                        // No response yet: the dump state sends them all.
                        rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
                        dump_idx_in  = '0;
                        state_in     = ST_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = ssi_pkg::COUNT_W'(cnt_in);
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               do_rotate       = 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_hit_in      = 1'b0;
               rsp_inserted_in = 1'b0;
               rsp_full_in     = 1'b0;
               rsp_count_in    = ssi_pkg::COUNT_W'(cnt_ff);
               rsp_element_in  = cell_data[0];
               rsp_last_in     = dump_last;
               dump_idx_in     = dump_idx_ff + 1'b1;
               if (dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dump_idx_ff     <= dump_idx_in;
      func_ff         <= func_in;
      key_ff          <= key_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_inserted_ff <= rsp_inserted_in;
      rsp_full_ff     <= rsp_full_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_element_ff  <= rsp_element_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.hit      = rsp_hit_ff;
   assign rsp_chan.inserted = rsp_inserted_ff;
   assign rsp_chan.full_res = rsp_full_ff;
   assign rsp_chan.count    = rsp_count_ff;
   assign rsp_chan.element  = rsp_element_ff;
   assign rsp_chan.last     = rsp_last_ff;

endmodule

// ----- hw/rtl/ssi_cell.sv -----
// One slot of the sorted chain: holds a key and the compare flags of the
// request under way.
module ssi_cell (
   input  logic                             clock,
   input  ssi_pkg::cell_ctrl_type           ctrl,
   input  logic                             slot_valid,
   input  logic                             slot_tail,
   input  logic signed [ssi_pkg::KEY_W-1:0] left_data,
   input  logic                             left_gt,
   input  logic signed [ssi_pkg::KEY_W-1:0] right_data,
   input  logic signed [ssi_pkg::KEY_W-1:0] head_data,
   output logic signed [ssi_pkg::KEY_W-1:0] data,
   output logic                             eq,
   output logic                             gt
);

   logic signed [ssi_pkg::KEY_W-1:0] data_ff, data_in;
   logic                             eq_ff, eq_in;
   logic                             gt_ff, gt_in;

   always_comb begin
      data_in = data_ff;
      eq_in   = eq_ff;
      gt_in   = gt_ff;
      if (ctrl.load_flags) begin
         eq_in = slot_valid && (data_ff == ctrl.key);
         gt_in = !slot_valid || (data_ff > ctrl.key);
      end
      if (ctrl.do_insert && gt_ff) begin
         // The first greater slot takes the new key, the rest shift right.
         data_in = left_gt ? left_data : ctrl.key;
      end else if (ctrl.do_rotate) begin
         data_in = slot_tail ? head_data : right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      eq_ff   <= eq_in;
      gt_ff   <= gt_in;
   end

   assign data = data_ff;
   assign eq   = eq_ff;
   assign gt   = gt_ff;

endmodule

// ----- hw/rtl/ssi_checker.sv -----
// Port-level checks of the sorted set.
module ssi_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_hit,
   input logic                             rsp_inserted,
   input logic                             rsp_full_res,
   input logic signed [ssi_pkg::KEY_W-1:0] rsp_element,
   input logic                             rsp_last
);

   // A waiting response stays valid and keeps its element and last flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_element) && $stable(rsp_last))
      else $error("response changed while stalled");

   // At most one outcome flag per response.
   a_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_hit, rsp_inserted, rsp_full_res}))
      else $error("conflicting outcome flags");

   // Each request keeps the controller busy, so no two requests are accepted back to back.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on consecutive cycles");

   // No response straight out of reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sorted_set_insert_search ssi_checker u_ssi_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_hit      (rsp_chan.hit),
   .rsp_inserted (rsp_chan.inserted),
   .rsp_full_res (rsp_chan.full_res),
   .rsp_element  (rsp_chan.element),
   .rsp_last     (rsp_chan.last)
);
